/* design/rmbtd_pkg.sv */
// rmbtd_pkg: shared types and constants of the red-minus-blue threshold and dilation block
// no dependencies
`default_nettype none

package rmbtd_pkg;

	localparam int PIX_W      = 8;
	localparam int SIZE_W     = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int WIN_W      = 9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd100;
	localparam int               WIDTH_RESET     = 640;
	localparam int               HEIGHT_RESET    = 480;
	localparam int               SIZE_MIN        = 2;

	// line store word: bit 0 two rows back, bit 1 previous row
	localparam int LS_W   = 2;
	localparam int LS_TOP = 0;
	localparam int LS_MID = 1;

	// window keep masks, window bits 3*k+j: column k (0 oldest), row j (0 top)
	localparam logic [WIN_W-1:0] KEEP_NO_RIGHT  = 9'h03F;
	localparam logic [WIN_W-1:0] KEEP_NO_LEFT   = 9'h1F8;
	localparam logic [WIN_W-1:0] KEEP_NO_ABOVE  = 9'h1B6;
	localparam logic [WIN_W-1:0] KEEP_NO_BELOW  = 9'h0DB;

	typedef struct packed {
		logic [PIX_W-1:0]  threshold;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	typedef struct packed {
		logic mbit;
		logic has_out;
		logic frame_end;
		logic right_edge;
		logic left_edge;
		logic top_row;
		logic bottom_row;
	} pos_t;

endpackage

`default_nettype wire

/* design/rmbtd_pix_if.sv */
// rmbtd_pix_if: pixel input channel, valid/ready with red, blue and flush
// depends on rmbtd_pkg
`default_nettype none

interface rmbtd_pix_if import rmbtd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red;
	logic [PIX_W-1:0] blue;
	logic             flush;

	modport source (output valid, red, blue, flush, input ready);
	modport sink (input valid, red, blue, flush, output ready);
endinterface

`default_nettype wire

/* design/rmbtd_res_if.sv */
// rmbtd_res_if: result channel, valid/ready with mask and frame_end
// no dependencies
`default_nettype none

interface rmbtd_res_if ();
	logic valid;
	logic ready;
	logic mask;
	logic frame_end;

	modport source (output valid, mask, frame_end, input ready);
	modport sink (input valid, mask, frame_end, output ready);
endinterface

`default_nettype wire

/* design/rmbtd_ram.sv */
// rmbtd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module rmbtd_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/rmbtd_cfg.sv */
// rmbtd_cfg: threshold and image size registers, sizes clamped on write
// depends on rmbtd_pkg
`default_nettype none

module rmbtd_cfg import rmbtd_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	localparam logic [SIZE_W:0] MAX_W_X = (SIZE_W+1)'(MAX_WIDTH);
	localparam logic [SIZE_W:0] MAX_H_X = (SIZE_W+1)'(MAX_HEIGHT);
	localparam logic [SIZE_W-1:0] W_RST =
		(WIDTH_RESET > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : SIZE_W'(WIDTH_RESET);
	localparam logic [SIZE_W-1:0] H_RST =
		(HEIGHT_RESET > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : SIZE_W'(HEIGHT_RESET);

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W:0] hi);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v < SIZE_W'(SIZE_MIN)) begin
			r = SIZE_W'(SIZE_MIN);
		end else if ({1'b0, v} > hi) begin
			r = hi[SIZE_W-1:0];
		end
		return r;
	endfunction

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= THRESHOLD_RESET;
			cfg_q.width     <= W_RST;
			cfg_q.height    <= H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= cfg_data[PIX_W-1:0];
				REG_WIDTH:     cfg_q.width     <= clamp_size(cfg_data[SIZE_W-1:0], MAX_W_X);
				REG_HEIGHT:    cfg_q.height    <= clamp_size(cfg_data[SIZE_W-1:0], MAX_H_X);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* design/rmbtd_scan.sv */
// rmbtd_scan: raster position counters, threshold, line store clear and input register
// depends on rmbtd_pkg, rmbtd_pix_if
`default_nettype none

module rmbtd_scan import rmbtd_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	rmbtd_pix_if.sink                         pixel,
	input  cfg_t                              cfg,
	input  wire logic                         take_s1,
	output pos_t                              pos_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]      col_s1,
	output logic                              valid_s1,
	output logic                              ram_re,
	output logic [$clog2(MAX_WIDTH)-1:0]      ram_raddr,
	output logic                              clr_busy,
	output logic [$clog2(MAX_WIDTH)-1:0]      clr_addr
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT + 4);
	localparam int CMPW = (RW + 1 > SIZE_W + 1) ? RW + 1 : SIZE_W + 1;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] clr_addr_q;
	logic          clr_busy_q;

	logic            accept;
	logic [CW-1:0]   c_cur;
	logic [RW-1:0]   r_cur;
	logic [CW:0]     c_inc;
	logic [CW-1:0]   col_n;
	logic [RW-1:0]   row_n;
	logic [CMPW-1:0] w_x;
	logic [CMPW-1:0] h_x;
	logic [CMPW-1:0] r_x;
	logic            c_is0;
	logic            past_h;
	logic            hit;
	pos_t            pos;

	assign pixel.ready = !clr_busy_q && (!valid_s1 || take_s1);
	assign accept      = pixel.valid && pixel.ready;

	always_comb begin
		w_x   = CMPW'(cfg.width);
		h_x   = CMPW'(cfg.height);
		c_cur = col_q;
		r_cur = row_q;
		if (CMPW'(col_q) >= w_x) begin
			c_cur = '0;
			r_cur = row_q + RW'(1);
		end
		if (CMPW'(r_cur) > h_x + CMPW'(1)) begin
			c_cur = '0;
			r_cur = '0;
		end
		r_x    = CMPW'(r_cur);
		c_is0  = (c_cur == '0);
		past_h = (r_x >= h_x + CMPW'(1));
		hit    = (pixel.red > pixel.blue) && ((pixel.red - pixel.blue) > cfg.threshold);

		pos.mbit       = !pixel.flush && (r_x < h_x) && hit;
		pos.has_out    = !((r_cur == '0) || ((r_cur == RW'(1)) && c_is0));
		pos.frame_end  = pos.has_out && c_is0 && past_h;
		pos.right_edge = c_is0;
		pos.left_edge  = (c_cur == CW'(1));
		pos.top_row    = c_is0 ? (r_cur == RW'(2)) : (r_cur == RW'(1));
		pos.bottom_row = c_is0 ? past_h : (r_x >= h_x);

		c_inc = {1'b0, c_cur} + (CW+1)'(1);
		col_n = c_inc[CW-1:0];
		row_n = r_cur;
		if (CMPW'(c_inc) >= w_x) begin
			col_n = '0;
			row_n = r_cur + RW'(1);
		end
		if (pos.frame_end) begin
			col_n = '0;
			row_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			valid_s1   <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + CW'(1);
				if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (accept) begin
				col_q    <= col_n;
				row_q    <= row_n;
				valid_s1 <= 1'b1;
			end else if (take_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
			col_s1 <= c_cur;
		end
	end

	assign ram_re    = accept;
	assign ram_raddr = c_cur;
	assign clr_busy  = clr_busy_q;
	assign clr_addr  = clr_addr_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> CMPW'(col_q) < CMPW'(cfg.width))
		else $error("column counter left the row");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos.frame_end |=> col_q == '0 && row_q == '0)
		else $error("frame end did not restart position");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> CMPW'(row_q) <= CMPW'(cfg.height) + CMPW'(2))
		else $error("row counter beyond flush region");

endmodule

`default_nettype wire

/* design/rmbtd_window.sv */
// rmbtd_window: 3x3 window shift, border masking, line store write-back, result register
// depends on rmbtd_pkg, rmbtd_res_if
`default_nettype none

module rmbtd_window import rmbtd_pkg::*; #(
	parameter int ADDR_W = 11
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  pos_t                   pos_s1,
	input  wire logic [ADDR_W-1:0] col_s1,
	input  wire logic              valid_s1,
	input  wire logic [LS_W-1:0]   rdata,
	output logic                   take_s1,
	output logic                   ram_we,
	output logic [ADDR_W-1:0]      ram_waddr,
	output logic [LS_W-1:0]        ram_wdata,
	rmbtd_res_if.source            result
);

	logic [WIN_W-1:0] window_q;
	logic [WIN_W-1:0] win_next;
	logic [WIN_W-1:0] win_m;
	logic             out_valid_q;
	logic             mask_q;
	logic             frame_end_q;

	assign take_s1 = valid_s1 && (!out_valid_q || result.ready);

	always_comb begin
		win_next = {pos_s1.mbit, rdata[LS_MID], rdata[LS_TOP], window_q[WIN_W-1:3]};
		win_m    = win_next;
		if (pos_s1.right_edge) begin
			win_m = win_m & KEEP_NO_RIGHT;
		end
		if (pos_s1.left_edge) begin
			win_m = win_m & KEEP_NO_LEFT;
		end
		if (pos_s1.top_row) begin
			win_m = win_m & KEEP_NO_ABOVE;
		end
		if (pos_s1.bottom_row) begin
			win_m = win_m & KEEP_NO_BELOW;
		end
	end

	// previous row moves up, this item's bit becomes the previous row
	assign ram_we    = take_s1;
	assign ram_waddr = col_s1;
	assign ram_wdata = {pos_s1.mbit, rdata[LS_MID]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				window_q    <= win_next;
				out_valid_q <= pos_s1.has_out;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && pos_s1.has_out) begin
			mask_q      <= (win_m != '0);
			frame_end_q <= pos_s1.frame_end;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.mask      = mask_q;
	assign result.frame_end = frame_end_q;

	a_frame_end_out: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && pos_s1.frame_end |=> result.valid && result.frame_end)
		else $error("frame end item produced no marked result");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && !pos_s1.has_out |=> !result.valid)
		else $error("result shown for an item without one");

	a_window_shift: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 |=> window_q[WIN_W-1:WIN_W-3] == $past({pos_s1.mbit, rdata[LS_MID],
			rdata[LS_TOP]}))
		else $error("window column not shifted in");

endmodule

`default_nettype wire

/* design/red_minus_blue_threshold_dilate.sv */
// red_minus_blue_threshold_dilate: top level, colour threshold with 3x3 binary dilation
// depends on rmbtd_pkg, rmbtd_pix_if, rmbtd_res_if, rmbtd_ram, rmbtd_cfg, rmbtd_scan,
// rmbtd_window
//
// pixel carries red, blue and flush in raster order; result carries the dilated mask
// bit and frame_end on the last pixel of a frame. both are valid/ready channels.
// threshold, width and height are written on cfg_we/cfg_index/cfg_data while idle;
// sizes are clamped to 2..MAX_WIDTH and 2..MAX_HEIGHT.
// throughput is one item per cycle while result.ready is high and no clearing runs;
// line stores are one ram read and one ram write per item, on separate ports. a result
// passes the input register, then the result register, after the item that causes it
// is accepted, and refers to the pixel one row and one column earlier. the first
// width+1 items of a frame give no result; after the last row, width+1 flush items
// push out the rest. after reset the line store ram is cleared, one entry a cycle, all
// MAX_WIDTH entries, during which pixel.ready stays low. configuration writes are taken
// at any time. when result.ready is low the result register holds; one more item can be
// taken into the input register, then pixel.ready drops until the result is taken.
`default_nettype none

module red_minus_blue_threshold_dilate import rmbtd_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	rmbtd_pix_if.sink                  pixel,
	rmbtd_res_if.source                result
);

	localparam int CW = $clog2(MAX_WIDTH);

	cfg_t            cfg;
	pos_t            pos_s1;
	logic [CW-1:0]   col_s1;
	logic            valid_s1;
	logic            take_s1;
	logic            rd_en;
	logic [CW-1:0]   rd_addr;
	logic [LS_W-1:0] rd_data;
	logic            clr_busy;
	logic [CW-1:0]   clr_addr;
	logic            win_we;
	logic [CW-1:0]   win_addr;
	logic [LS_W-1:0] win_data;
	logic            wr_en;
	logic [CW-1:0]   wr_addr;
	logic [LS_W-1:0] wr_data;

	rmbtd_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rmbtd_scan #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.cfg       (cfg),
		.take_s1   (take_s1),
		.pos_s1    (pos_s1),
		.col_s1    (col_s1),
		.valid_s1  (valid_s1),
		.ram_re    (rd_en),
		.ram_raddr (rd_addr),
		.clr_busy  (clr_busy),
		.clr_addr  (clr_addr)
	);

	rmbtd_window #(
		.ADDR_W (CW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_s1    (pos_s1),
		.col_s1    (col_s1),
		.valid_s1  (valid_s1),
		.rdata     (rd_data),
		.take_s1   (take_s1),
		.ram_we    (win_we),
		.ram_waddr (win_addr),
		.ram_wdata (win_data),
		.result    (result)
	);

	// clearing pass owns the write port after reset
	assign wr_en   = clr_busy || win_we;
	assign wr_addr = clr_busy ? clr_addr : win_addr;
	assign wr_data = clr_busy ? '0 : win_data;

	rmbtd_ram #(
		.WIDTH (LS_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

endmodule

`default_nettype wire
